### rtl/adcasc_pkg.sv
package adcasc_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int REF_W    = 13;
    localparam int ADC_BITS = 10;
    localparam int PROD_W   = SAMPLE_W + REF_W;
    localparam int MV_W     = 14;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 3;

    // reset value and saturation limit
    localparam logic [REF_W-1:0] REF_RESET = 13'd5000;
    localparam logic [MV_W-1:0]  MV_LIMIT  = 14'd9999;

    // decimal place weights
    localparam logic [MV_W-1:0] UNIT_THOUSANDS = 14'd1000;
    localparam logic [MV_W-1:0] UNIT_HUNDREDS  = 14'd100;
    localparam logic [MV_W-1:0] UNIT_TENS      = 14'd10;

    // character codes
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;
    localparam logic [7:0] ASCII_CR   = 8'h0D;

    // byte positions within one sample's text
    localparam logic [POS_W-1:0] POS_HUNDREDS = 3'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 3'd1;
    localparam logic [POS_W-1:0] POS_UNITS    = 3'd2;
    localparam logic [POS_W-1:0] POS_DOT      = 3'd3;
    localparam logic [POS_W-1:0] POS_FRAC     = 3'd4;
    localparam logic [POS_W-1:0] POS_CR       = 3'd5;

    // millivolt digits, thousands down to ones
    typedef struct packed {
        logic [DIGIT_W-1:0] d3;
        logic [DIGIT_W-1:0] d2;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d0;
    } digits_t;

    // one decimal digit by parallel compares, value below ten units
    function automatic logic [DIGIT_W-1:0] digit_at(input logic [MV_W-1:0] v,
                                                   input logic [MV_W-1:0] unit);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int k = 1; k < 10; k++) begin
            if (32'(v) >= 32'(unit) * 32'(k)) begin
                d = DIGIT_W'(k);
            end
        end
        return d;
    endfunction

    // remainder after taking out one digit
    function automatic logic [MV_W-1:0] strip_digit(input logic [MV_W-1:0] v,
                                                    input logic [DIGIT_W-1:0] d,
                                                    input logic [MV_W-1:0] unit);
        return MV_W'(32'(v) - 32'(d) * 32'(unit));
    endfunction

    // ascii character of one digit
    function automatic logic [7:0] to_ascii(input logic [DIGIT_W-1:0] d);
        return ASCII_ZERO | {4'b0000, d};
    endfunction

endpackage

### rtl/adc_sample_to_ascii_decimal.sv
// path: an accepted sample passes stages s1 to s5, the serializer and then the output register
// throughput: one text byte per cycle while text_stall is low; each sample gives four to six
//   bytes, so the byte serializer feeding the output register sets the sample rate
// five pipeline stages (multiply, scale, three digit stages) accept one sample a cycle while sample_stall is low
// reset: async active low, empties all stages, the reference register returns to 5000
module adc_sample_to_ascii_decimal (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ref_millivolts_we,
    input  logic [adcasc_pkg::REF_W-1:0]    ref_millivolts,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [adcasc_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                            text_valid,
    input  logic                            text_stall,
    output logic [7:0]                      text_byte,
    output logic                            last_byte
);
    import adcasc_pkg::*;

    logic [REF_W-1:0]   ref_reg;

    logic               s1_valid_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic               s2_valid_reg;
    logic [MV_W-1:0]    s2_mv_reg;
    logic               s3_valid_reg;
    logic [DIGIT_W-1:0] s3_d3_reg;
    logic [MV_W-1:0]    s3_rem_reg;
    logic               s4_valid_reg;
    logic [DIGIT_W-1:0] s4_d3_reg;
    logic [DIGIT_W-1:0] s4_d2_reg;
    logic [MV_W-1:0]    s4_rem_reg;
    logic               s5_valid_reg;
    digits_t            s5_digits_reg;

    logic               ser_valid_reg;
    digits_t            ser_digits_reg;
    logic [POS_W-1:0]   ser_pos_reg;

    logic               text_valid_reg;
    logic [7:0]         text_byte_reg;
    logic               last_byte_reg;

    logic               s1_ready;
    logic               s2_ready;
    logic               s3_ready;
    logic               s4_ready;
    logic               s5_ready;
    logic               ser_ready;
    logic               out_ready;
    logic               ser_emit;
    logic               ser_done;
    logic               ser_load;

    logic [PROD_W-1:0]  scaled;
    logic [MV_W-1:0]    mv_next;
    logic [DIGIT_W-1:0] d3_next;
    logic [DIGIT_W-1:0] d2_next;
    logic [DIGIT_W-1:0] d1_next;
    logic [MV_W-1:0]    rem4_ones;
    logic [POS_W-1:0]   start_pos;
    logic [7:0]         byte_next;

    // reference register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
        end
        else if (ref_millivolts_we)
        begin
            ref_reg <= ref_millivolts;
        end
    end

    // backpressure chain, a stage moves when it is empty or its successor takes it
    assign out_ready = !text_valid_reg || !text_stall;
    assign ser_emit  = ser_valid_reg && out_ready;
    assign ser_done  = ser_emit && (ser_pos_reg == POS_CR);
    assign ser_ready = !ser_valid_reg || ser_done;
    assign s5_ready  = !s5_valid_reg || ser_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign ser_load  = s5_valid_reg && ser_ready;

    // scale and saturate
    always_comb
    begin
        scaled = s1_prod_reg >> ADC_BITS;
        if (scaled > PROD_W'(MV_LIMIT))
        begin
            mv_next = MV_LIMIT;
        end
        else
        begin
            mv_next = scaled[MV_W-1:0];
        end
    end

    // digit extraction
    assign d3_next   = digit_at(s2_mv_reg, UNIT_THOUSANDS);
    assign d2_next   = digit_at(s3_rem_reg, UNIT_HUNDREDS);
    assign d1_next   = digit_at(s4_rem_reg, UNIT_TENS);
    assign rem4_ones = strip_digit(s4_rem_reg, d1_next, UNIT_TENS);

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && sample_valid)
        begin
            s1_prod_reg <= PROD_W'(adc_sample) * PROD_W'(ref_reg);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_mv_reg <= mv_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_d3_reg  <= d3_next;
            s3_rem_reg <= strip_digit(s2_mv_reg, d3_next, UNIT_THOUSANDS);
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_d3_reg  <= s3_d3_reg;
            s4_d2_reg  <= d2_next;
            s4_rem_reg <= strip_digit(s3_rem_reg, d2_next, UNIT_HUNDREDS);
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_digits_reg.d3 <= s4_d3_reg;
            s5_digits_reg.d2 <= s4_d2_reg;
            s5_digits_reg.d1 <= d1_next;
            s5_digits_reg.d0 <= rem4_ones[DIGIT_W-1:0];
        end
    end

    // first byte position, leading zeros dropped but one integer digit kept
    always_comb
    begin
        if (s5_digits_reg.d3 != '0)
        begin
            start_pos = POS_HUNDREDS;
        end
        else if (s5_digits_reg.d2 != '0)
        begin
            start_pos = POS_TENS;
        end
        else
        begin
            start_pos = POS_UNITS;
        end
    end

    // serializer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_pos_reg   <= POS_HUNDREDS;
        end
        else if (ser_load)
        begin
            ser_valid_reg <= 1'b1;
            ser_pos_reg   <= start_pos;
        end
        else if (ser_done)
        begin
            ser_valid_reg <= 1'b0;
        end
        else if (ser_emit)
        begin
            ser_pos_reg <= ser_pos_reg + 1'b1;
        end
    end

    // serializer digits
    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_digits_reg <= s5_digits_reg;
        end
    end

    // byte select
    always_comb
    begin
        unique case (ser_pos_reg)
            POS_HUNDREDS: byte_next = to_ascii(ser_digits_reg.d3);
            POS_TENS:     byte_next = to_ascii(ser_digits_reg.d2);
            POS_UNITS:    byte_next = to_ascii(ser_digits_reg.d1);
            POS_DOT:      byte_next = ASCII_DOT;
            POS_FRAC:     byte_next = to_ascii(ser_digits_reg.d0);
            POS_CR:       byte_next = ASCII_CR;
            default:      byte_next = ASCII_CR;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            text_valid_reg <= ser_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_emit)
        begin
            text_byte_reg <= byte_next;
            last_byte_reg <= (ser_pos_reg == POS_CR);
        end
    end

    assign text_valid = text_valid_reg;
    assign text_byte  = text_byte_reg;
    assign last_byte  = last_byte_reg;

endmodule

### rtl/adcasc_checker.sv
module adcasc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       last_byte
);
    import adcasc_pkg::*;

    // a stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_stall |=> text_valid && $stable(text_byte) && $stable(last_byte))
        else $error("stalled text request changed");

    // last flag only on the carriage return
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && last_byte |-> text_byte == ASCII_CR)
        else $error("last flag on a byte other than carriage return");

    // carriage return only as the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !last_byte |-> text_byte != ASCII_CR)
        else $error("carriage return without last flag");

    // a fraction digit follows the decimal point with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall && text_byte == ASCII_DOT |=>
            text_valid && text_byte >= ASCII_ZERO && text_byte <= (ASCII_ZERO + 8'd9))
        else $error("no fraction digit right after decimal point");

endmodule

bind adc_sample_to_ascii_decimal adcasc_checker u_adcasc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .last_byte  (last_byte)
);
